FILE: rtl/core/csia_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csia_pkg
// Types, operation codes and small helper functions shared by the checked
// saturating integer ALU and its divider stage.
// ----------------------------------------------------------------------------
package csia_pkg;

    localparam int unsigned DataW    = 64;
    localparam int unsigned DivSteps = 64;

    typedef logic [DataW-1:0] t_word;

    typedef struct packed {
        logic [4:0] action;
        logic [2:0] int_type;
        t_word      operand_a;
        t_word      operand_b;
    } t_in;

    typedef struct packed {
        t_word      result;
        logic [1:0] status;
        logic       absent;
    } t_out;

    localparam logic [4:0] ACT_AND  = 5'd0;
    localparam logic [4:0] ACT_OR   = 5'd1;
    localparam logic [4:0] ACT_XOR  = 5'd2;
    localparam logic [4:0] ACT_SHL  = 5'd3;
    localparam logic [4:0] ACT_SHR  = 5'd4;
    localparam logic [4:0] ACT_CADD = 5'd5;
    localparam logic [4:0] ACT_CSUB = 5'd6;
    localparam logic [4:0] ACT_CMUL = 5'd7;
    localparam logic [4:0] ACT_OADD = 5'd8;
    localparam logic [4:0] ACT_OSUB = 5'd9;
    localparam logic [4:0] ACT_OMUL = 5'd10;
    localparam logic [4:0] ACT_WADD = 5'd11;
    localparam logic [4:0] ACT_WSUB = 5'd12;
    localparam logic [4:0] ACT_WMUL = 5'd13;
    localparam logic [4:0] ACT_SADD = 5'd14;
    localparam logic [4:0] ACT_SSUB = 5'd15;
    localparam logic [4:0] ACT_SMUL = 5'd16;
    localparam logic [4:0] ACT_DIV  = 5'd17;
    localparam logic [4:0] ACT_MOD  = 5'd18;
    localparam logic [4:0] ACT_LT   = 5'd19;
    localparam logic [4:0] ACT_LE   = 5'd20;
    localparam logic [4:0] ACT_GT   = 5'd21;
    localparam logic [4:0] ACT_GE   = 5'd22;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_DIV0  = 2'd2;
    localparam logic [1:0] ST_SHIFT = 2'd3;

    typedef enum logic [1:0] {
        K_CHECKED,
        K_OPTIONAL,
        K_WRAP,
        K_SAT
    } t_kind;

    function automatic t_word fn_mask(input logic [1:0] wsel);
        t_word m;
        case (wsel)
            2'd0:    m = t_word'(64'h0000_0000_0000_00FF);
            2'd1:    m = t_word'(64'h0000_0000_0000_FFFF);
            2'd2:    m = t_word'(64'h0000_0000_FFFF_FFFF);
            default: m = '1;
        endcase
        return m;
    endfunction

    function automatic t_word fn_sbit(input logic [1:0] wsel);
        t_word s;
        case (wsel)
            2'd0:    s = t_word'(64'h0000_0000_0000_0080);
            2'd1:    s = t_word'(64'h0000_0000_0000_8000);
            2'd2:    s = t_word'(64'h0000_0000_8000_0000);
            default: s = t_word'(64'h8000_0000_0000_0000);
        endcase
        return s;
    endfunction

    function automatic t_kind fn_kind(input logic [4:0] act);
        t_kind k;
        case (act)
            ACT_CADD, ACT_CSUB, ACT_CMUL: k = K_CHECKED;
            ACT_OADD, ACT_OSUB, ACT_OMUL: k = K_OPTIONAL;
            ACT_WADD, ACT_WSUB, ACT_WMUL: k = K_WRAP;
            default:                      k = K_SAT;
        endcase
        return k;
    endfunction

    // Applies the overflow policy of the operation family to a raw result.
    function automatic t_out fn_apply(input t_kind k, input logic ov,
                                      input t_word w, input t_word satv);
        t_out o;
        o = '{result: '0, status: ST_OK, absent: 1'b0};
        case (k)
            K_CHECKED: begin
                if (ov) o.status = ST_OVF;
                else    o.result = w;
            end
            K_OPTIONAL: begin
                if (ov) o.absent = 1'b1;
                else    o.result = w;
            end
            K_WRAP:  o.result = w;
            default: o.result = ov ? satv : w;
        endcase
        return o;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/csia_div_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csia_div_stage
// One registered step of a restoring radix-2 unsigned divider. Each step
// brings down one dividend bit and produces one quotient bit.
// ----------------------------------------------------------------------------
module csia_div_stage (
    input  wire                    i_clk,
    input  wire                    i_en,
    input  wire csia_pkg::t_word   i_rem,
    input  wire csia_pkg::t_word   i_quo,
    input  wire csia_pkg::t_word   i_dvs,
    output csia_pkg::t_word        o_rem,
    output csia_pkg::t_word        o_quo,
    output csia_pkg::t_word        o_dvs
);
    import csia_pkg::*;

    logic [DataW:0]   w_sh;
    logic [DataW+1:0] w_diff;
    logic             w_take;
    t_word            r_rem;
    t_word            r_quo;
    t_word            r_dvs;
    t_word            n_rem;
    t_word            n_quo;

    // The shifted remainder is below twice the divisor, so a successful
    // subtract always fits back into one word.
    always_comb begin
        w_sh   = {i_rem, i_quo[DataW-1]};
        w_diff = {1'b0, w_sh} - {2'b00, i_dvs};
        w_take = ~w_diff[DataW+1];
        n_rem  = w_take ? w_diff[DataW-1:0] : w_sh[DataW-1:0];
        n_quo  = {i_quo[DataW-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_dvs <= i_dvs;
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_dvs = r_dvs;

endmodule
`default_nettype wire

FILE: rtl/core/checked_saturating_integer_alu_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// checked_saturating_integer_alu_unit
// Fully pipelined integer ALU for 8/16/32/64-bit signed and unsigned
// operands with checked, optional, wrapping and saturating arithmetic.
// ----------------------------------------------------------------------------
// The unit accepts one transaction per clock while o_stall is low and
// returns exactly one result transaction for each, in order. Each result
// passes through 67 register stages (the first of which loads at the
// accepting edge). The pipeline depth is set by the divider: a 64-bit
// restoring divider with one quotient bit per pipeline stage. Every
// operation travels through the same pipeline so results never reorder.
// The stages are: an input register, a prepare stage (operand masking, sign
// handling, logic, shifts, add, subtract, compare), sixty-four divider
// steps, and the output register. The multiplier runs beside the first
// divider steps as four 32x32 partial products, a combine stage and a sign
// and overflow stage. A stall on the output freezes the whole pipeline, so
// nothing is lost or repeated; o_stall rises only while a finished result
// waits to be taken. There is no state between transactions and no
// configuration.
// ----------------------------------------------------------------------------
module checked_saturating_integer_alu_unit (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire csia_pkg::t_in    i_data,
    output logic                  o_valid,
    input  wire                   i_stall,
    output csia_pkg::t_out        o_data
);
    import csia_pkg::*;

    // Global advance. The pipeline moves whenever the output register is
    // empty or its transaction is being taken.
    logic w_en;

    // Input register.
    logic r_p_vld;
    t_in  r_p_in;

    // Control and partial result carried down the pipeline. Index zero is
    // the prepare stage output; index k+1 is aligned with divider step k.
    logic       r_vld [0:DivSteps];
    logic [4:0] r_act [0:DivSteps];
    logic [2:0] r_ty  [0:DivSteps];
    logic       r_an  [0:DivSteps];
    logic       r_bn  [0:DivSteps];
    t_word      r_res [0:DivSteps];
    logic [1:0] r_st  [0:DivSteps];
    logic       r_abs [0:DivSteps];

    // Magnitudes feeding the multiplier and the divider.
    t_word r_ma;
    t_word r_mb;

    // Divider chain.
    t_word w_rem [0:DivSteps];
    t_word w_quo [0:DivSteps];
    t_word w_dvs [0:DivSteps];

    // Multiplier pipeline.
    t_word r_pp_ll;
    t_word r_pp_lh;
    t_word r_pp_hl;
    t_word r_pp_hh;
    t_word r_mhi;
    t_word r_mlo;
    logic [33:0] w_mid;
    t_word n_mhi;
    t_word n_mlo;

    // Prepare stage signals.
    logic       q_sig;
    logic [6:0] q_bits;
    t_word      q_m;
    t_word      q_sb;
    t_word      q_a;
    t_word      q_b;
    logic       q_an;
    logic       q_bn;
    t_word      q_sa;
    t_word      q_sbx;
    t_word      q_ma;
    t_word      q_mb;
    t_word      q_wadd;
    t_word      q_wsub;
    logic       q_ovadd;
    logic       q_ovsub;
    t_word      q_satadd;
    t_word      q_satsub;
    t_word      q_xa;
    t_word      q_xb;
    t_out       q_o;

    // Multiply merge signals.
    logic  m_sig;
    logic  m_neg;
    t_word m_m;
    t_word m_sb;
    t_word m_lim;
    t_word m_w;
    logic  m_ov;
    t_word m_satv;
    t_out  m_o;

    // Final stage signals.
    t_word f_q;
    t_word f_r;
    t_word f_res;
    t_out  n_out;

    logic r_ovld;
    t_out r_out;

    assign w_en    = ~(r_ovld & i_stall);
    assign o_stall = ~w_en;

    // ---------------------------------------------------------------- input
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_en) begin
            r_p_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_in <= i_data;
        end
    end

    // -------------------------------------------------------------- prepare
    // Everything but multiply and divide finishes here. For divide and
    // remainder only the trap cases are decided; the quotient comes later.
    always_comb begin
        q_sig  = r_p_in.int_type[2];
        q_bits = 7'd8 << r_p_in.int_type[1:0];
        q_m    = fn_mask(r_p_in.int_type[1:0]);
        q_sb   = fn_sbit(r_p_in.int_type[1:0]);
        q_a    = r_p_in.operand_a & q_m;
        q_b    = r_p_in.operand_b & q_m;
        q_an   = q_sig & (|(q_a & q_sb));
        q_bn   = q_sig & (|(q_b & q_sb));
        q_sa   = q_an ? (q_a | ~q_m) : q_a;
        q_sbx  = q_bn ? (q_b | ~q_m) : q_b;
        q_ma   = q_an ? (t_word'(0) - q_sa) : q_a;
        q_mb   = q_bn ? (t_word'(0) - q_sbx) : q_b;

        q_wadd = (q_a + q_b) & q_m;
        q_wsub = (q_a - q_b) & q_m;
        if (q_sig) begin
            q_ovadd  = (q_an == q_bn) && ((|(q_wadd & q_sb)) != q_an);
            q_ovsub  = (q_an != q_bn) && ((|(q_wsub & q_sb)) != q_an);
            q_satadd = q_an ? q_sb : (q_sb - t_word'(1));
            q_satsub = q_satadd;
        end else begin
            q_ovadd  = q_wadd < q_a;
            q_ovsub  = q_a < q_b;
            q_satadd = q_m;
            q_satsub = '0;
        end

        // Signed order compares as unsigned once the sign bits are flipped.
        q_xa = q_sig ? (q_a ^ q_sb) : q_a;
        q_xb = q_sig ? (q_b ^ q_sb) : q_b;

        q_o = '{result: '0, status: ST_OK, absent: 1'b0};
        case (r_p_in.action)
            ACT_AND: q_o.result = q_a & q_b;
            ACT_OR:  q_o.result = q_a | q_b;
            ACT_XOR: q_o.result = q_a ^ q_b;
            ACT_SHL, ACT_SHR: begin
                if (q_b >= t_word'(q_bits)) begin
                    q_o.status = ST_SHIFT;
                end else if (r_p_in.action == ACT_SHL) begin
                    q_o.result = q_a << q_b[5:0];
                end else if (q_sig) begin
                    q_o.result = t_word'($signed(q_sa) >>> q_b[5:0]);
                end else begin
                    q_o.result = q_a >> q_b[5:0];
                end
            end
            ACT_CADD, ACT_OADD, ACT_WADD, ACT_SADD:
                q_o = fn_apply(fn_kind(r_p_in.action), q_ovadd, q_wadd, q_satadd);
            ACT_CSUB, ACT_OSUB, ACT_WSUB, ACT_SSUB:
                q_o = fn_apply(fn_kind(r_p_in.action), q_ovsub, q_wsub, q_satsub);
            ACT_DIV, ACT_MOD: begin
                if (q_b == '0) begin
                    q_o.status = ST_DIV0;
                end else if (q_sig && (q_a == q_sb) && (q_b == q_m)) begin
                    q_o.status = ST_OVF;
                end
            end
            ACT_LT: q_o.result = t_word'(q_xa <  q_xb);
            ACT_LE: q_o.result = t_word'(q_xa <= q_xb);
            ACT_GT: q_o.result = t_word'(q_xa >  q_xb);
            ACT_GE: q_o.result = t_word'(q_xa >= q_xb);
            default: q_o = '{result: '0, status: ST_OK, absent: 1'b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_act[0] <= r_p_in.action;
            r_ty[0]  <= r_p_in.int_type;
            r_an[0]  <= q_an;
            r_bn[0]  <= q_bn;
            r_res[0] <= q_o.result;
            r_st[0]  <= q_o.status;
            r_abs[0] <= q_o.absent;
            r_ma     <= q_ma;
            r_mb     <= q_mb;
        end
    end

    // ----------------------------------------------------------- multiplier
    // Stage one: four independent 32x32 partial products of the magnitudes.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pp_ll <= r_ma[31:0]  * r_mb[31:0];
            r_pp_lh <= r_ma[31:0]  * r_mb[63:32];
            r_pp_hl <= r_ma[63:32] * r_mb[31:0];
            r_pp_hh <= r_ma[63:32] * r_mb[63:32];
        end
    end

    // Stage two: combine into the full 128-bit product.
    always_comb begin
        w_mid = 34'(r_pp_ll[63:32]) + 34'(r_pp_lh[31:0]) + 34'(r_pp_hl[31:0]);
        n_mlo = {w_mid[31:0], r_pp_ll[31:0]};
        n_mhi = r_pp_hh + t_word'(r_pp_lh[63:32]) + t_word'(r_pp_hl[63:32])
              + t_word'(w_mid[33:32]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mhi <= n_mhi;
            r_mlo <= n_mlo;
        end
    end

    // Stage three: restore the sign, detect overflow and apply the policy.
    // The negated low word equals the two's complement product modulo the
    // width, so wrapping results come from the same product.
    always_comb begin
        m_sig  = r_ty[2][2];
        m_neg  = r_an[2] ^ r_bn[2];
        m_m    = fn_mask(r_ty[2][1:0]);
        m_sb   = fn_sbit(r_ty[2][1:0]);
        m_w    = (m_neg ? (t_word'(0) - r_mlo) : r_mlo) & m_m;
        if (m_sig) begin
            m_lim  = m_neg ? m_sb : (m_sb - t_word'(1));
            m_satv = m_lim;
        end else begin
            m_lim  = m_m;
            m_satv = m_m;
        end
        m_ov = (r_mhi != '0) || (r_mlo > m_lim);
        m_o  = fn_apply(fn_kind(r_act[2]), m_ov, m_w, m_satv);
    end

    // ------------------------------------------------------ carried control
    for (genvar j = 1; j <= DivSteps; j++) begin : g_carry
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (w_en) begin
                r_vld[j] <= r_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_act[j] <= r_act[j-1];
                r_ty[j]  <= r_ty[j-1];
                r_an[j]  <= r_an[j-1];
                r_bn[j]  <= r_bn[j-1];
            end
        end

        if (j == 3) begin : g_mul_merge
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    if ((r_act[2] == ACT_CMUL) || (r_act[2] == ACT_OMUL) ||
                        (r_act[2] == ACT_WMUL) || (r_act[2] == ACT_SMUL)) begin
                        r_res[j] <= m_o.result;
                        r_st[j]  <= m_o.status;
                        r_abs[j] <= m_o.absent;
                    end else begin
                        r_res[j] <= r_res[j-1];
                        r_st[j]  <= r_st[j-1];
                        r_abs[j] <= r_abs[j-1];
                    end
                end
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_res[j] <= r_res[j-1];
                    r_st[j]  <= r_st[j-1];
                    r_abs[j] <= r_abs[j-1];
                end
            end
        end
    end

    // -------------------------------------------------------------- divider
    assign w_rem[0] = '0;
    assign w_quo[0] = r_ma;
    assign w_dvs[0] = r_mb;

    for (genvar k = 0; k < DivSteps; k++) begin : g_div
        csia_div_stage u_step (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (w_rem[k]),
            .i_quo (w_quo[k]),
            .i_dvs (w_dvs[k]),
            .o_rem (w_rem[k+1]),
            .o_quo (w_quo[k+1]),
            .o_dvs (w_dvs[k+1])
        );
    end

    // ---------------------------------------------------------------- final
    // The quotient truncates toward zero and the remainder follows the sign
    // of the dividend. Every result is masked to the selected width here.
    always_comb begin
        f_q   = w_quo[DivSteps];
        f_r   = w_rem[DivSteps];
        f_res = r_res[DivSteps];
        if (((r_act[DivSteps] == ACT_DIV) || (r_act[DivSteps] == ACT_MOD)) &&
            (r_st[DivSteps] == ST_OK)) begin
            if (r_act[DivSteps] == ACT_DIV) begin
                f_res = (r_an[DivSteps] ^ r_bn[DivSteps]) ? (t_word'(0) - f_q) : f_q;
            end else begin
                f_res = r_an[DivSteps] ? (t_word'(0) - f_r) : f_r;
            end
        end
        n_out.result = f_res & fn_mask(r_ty[DivSteps][1:0]);
        n_out.status = r_st[DivSteps];
        n_out.absent = r_abs[DivSteps];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= r_vld[DivSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_ovld;
    assign o_data  = r_out;

    // ----------------------------------------------------------- assertions
    a_trap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.status != ST_OK)) |-> (o_data.result == '0))
        else $error("trap transaction with nonzero result");

    a_absent_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.absent) |-> ((o_data.status == ST_OK) && (o_data.result == '0)))
        else $error("absent result carries data or status");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[DivSteps]) |=> o_valid)
        else $error("transaction lost between divider and output register");

endmodule
`default_nettype wire
